// File: sv/tfcw_pkg.sv
// ----------------------------------------------------------------------------
// tfcw_pkg
// Shared constants, request codes, types and address helpers for the text
// frame cursor writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tfcw_pkg;

  localparam int COLUMNS = 40;
  localparam int ROWS    = 24;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS + 1);
  localparam int ROW_W   = $clog2(ROWS + 1);

  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] CR_CODE    = 8'h0D;
  localparam logic [7:0] LF_CODE    = 8'h0A;
  localparam logic [7:0] NUL_CODE   = 8'h00;

  localparam logic [3:0] REQ_PUT      = 4'd0;
  localparam logic [3:0] REQ_SET      = 4'd1;
  localparam logic [3:0] REQ_CLEAR    = 4'd2;
  localparam logic [3:0] REQ_CLR_LINE = 4'd3;
  localparam logic [3:0] REQ_LEFT     = 4'd4;
  localparam logic [3:0] REQ_RIGHT    = 4'd5;
  localparam logic [3:0] REQ_UP       = 4'd6;
  localparam logic [3:0] REQ_DOWN     = 4'd7;
  localparam logic [3:0] REQ_SCROLL   = 4'd8;
  localparam logic [3:0] REQ_READ     = 4'd9;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_ok;
    logic [5:0] cursor_col;
    logic [4:0] cursor_row;
    logic       frame_dirty;
  } result_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
    cell_addr = ADDR_W'((int'(row) - 1) * COLUMNS + int'(col) - 1);
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(input logic [6:0] v);
    if (v == 7'd0) begin
      clamp_col = COL_W'(1);
    end else if (v > 7'(COLUMNS)) begin
      clamp_col = COL_W'(COLUMNS);
    end else begin
      clamp_col = COL_W'(v);
    end
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic [6:0] v);
    if (v == 7'd0) begin
      clamp_row = ROW_W'(1);
    end else if (v > 7'(ROWS)) begin
      clamp_row = ROW_W'(ROWS);
    end else begin
      clamp_row = ROW_W'(v);
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/tfcw_cell_mem.sv
// ----------------------------------------------------------------------------
// tfcw_cell_mem
// Character cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcw_cell_mem (
  input  wire logic             clk,
  input  wire tfcw_pkg::mem_req_t mem_req,
  output logic [7:0]            rd_data
);
  import tfcw_pkg::*;

  logic [7:0] mem [CELLS];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: sv/tfcw_ctrl.sv
// ----------------------------------------------------------------------------
// tfcw_ctrl
// Command sequencer: cursor state, dirty mark and the shared address walker
// that drives fill and copy sweeps over the cell store.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_req_type,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [6:0]         in_target_col,
  input  wire logic [6:0]         in_target_row,
  input  wire logic [4:0]         in_line_count,
  input  wire logic               in_wrap_enable,
  input  wire logic [7:0]         rd_data,
  output tfcw_pkg::mem_req_t      mem_req,
  output logic                    res_valid,
  input  wire logic               res_take,
  output tfcw_pkg::result_t       result
);
  import tfcw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WAIT = 3'd1;
  localparam logic [2:0] S_COPY = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic              init_r, init_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic              dirty_r, dirty_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] last_r, last_nxt;
  logic [ADDR_W-1:0] shift_r, shift_nxt;
  logic              rok_r, rok_nxt;
  logic              wr_en_r, wr_en_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              wr_copy_r, wr_copy_nxt;
  logic [7:0]        wr_data_r, wr_data_nxt;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic              idle;
  logic              accept;
  logic              do_nl;
  logic              row_ok;

  // hold off while the last write of the power-up fill is still pending
  assign idle   = (state_r == S_IDLE) && !wr_en_r;
  assign accept = in_valid && idle;
  assign row_ok = (in_target_row != 7'd0) && (in_target_row <= 7'(ROWS));

  always_comb begin
    state_nxt   = state_r;
    init_nxt    = init_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    dirty_nxt   = dirty_r;
    ptr_nxt     = ptr_r;
    last_nxt    = last_r;
    shift_nxt   = shift_r;
    rok_nxt     = rok_r;
    wr_en_nxt   = 1'b0;
    wr_addr_nxt = wr_addr_r;
    wr_copy_nxt = wr_copy_r;
    wr_data_nxt = wr_data_r;
    re          = 1'b0;
    raddr       = ptr_r + shift_r;
    do_nl       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rok_nxt   = 1'b0;
          state_nxt = S_DONE;
          case (in_req_type)
            REQ_PUT: begin
              if (in_char_code == NUL_CODE) begin
                cur_col_nxt = cur_col_r;
              end else if (in_char_code == CR_CODE) begin
                cur_col_nxt = COL_W'(1);
              end else if (in_char_code == LF_CODE) begin
                do_nl = 1'b1;
              end else begin
                dirty_nxt   = 1'b1;
                wr_en_nxt   = 1'b1;
                wr_copy_nxt = 1'b0;
                wr_addr_nxt = cell_addr(cur_col_r, cur_row_r);
                wr_data_nxt = in_char_code;
                if (cur_col_r == COL_W'(COLUMNS)) begin
                  do_nl = 1'b1;
                end else begin
                  cur_col_nxt = cur_col_r + 1'b1;
                end
              end
            end
            REQ_SET: begin
              cur_col_nxt = clamp_col(in_target_col);
              cur_row_nxt = clamp_row(in_target_row);
            end
            REQ_CLEAR: begin
              cur_col_nxt = COL_W'(1);
              cur_row_nxt = ROW_W'(1);
              dirty_nxt   = 1'b1;
              ptr_nxt     = '0;
              last_nxt    = ADDR_W'(CELLS - 1);
              state_nxt   = S_FILL;
            end
            REQ_CLR_LINE: begin
              cur_col_nxt = COL_W'(1);
              dirty_nxt   = 1'b1;
              ptr_nxt     = cell_addr(COL_W'(1), cur_row_r);
              last_nxt    = cell_addr(COL_W'(COLUMNS), cur_row_r);
              state_nxt   = S_FILL;
            end
            REQ_LEFT: begin
              if (cur_col_r <= COL_W'(1)) begin
                if (in_wrap_enable) cur_col_nxt = COL_W'(COLUMNS);
              end else begin
                cur_col_nxt = cur_col_r - 1'b1;
              end
            end
            REQ_RIGHT: begin
              if (cur_col_r >= COL_W'(COLUMNS)) begin
                if (in_wrap_enable) cur_col_nxt = COL_W'(1);
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
              end
            end
            REQ_UP: begin
              if (cur_row_r <= ROW_W'(1)) begin
                if (in_wrap_enable) cur_row_nxt = ROW_W'(ROWS);
              end else begin
                cur_row_nxt = cur_row_r - 1'b1;
              end
            end
            REQ_DOWN: begin
              if (cur_row_r >= ROW_W'(ROWS)) begin
                if (in_wrap_enable) cur_row_nxt = ROW_W'(1);
              end else begin
                cur_row_nxt = cur_row_r + 1'b1;
              end
            end
            REQ_SCROLL: begin
              if (in_line_count != 5'd0) begin
                dirty_nxt = 1'b1;
                ptr_nxt   = '0;
                if (int'(in_line_count) >= ROWS) begin
                  last_nxt  = ADDR_W'(CELLS - 1);
                  state_nxt = S_FILL;
                end else begin
                  shift_nxt = ADDR_W'(int'(in_line_count) * COLUMNS);
                  last_nxt  = ADDR_W'((ROWS - int'(in_line_count)) * COLUMNS - 1);
                  state_nxt = S_COPY;
                end
              end
            end
            REQ_READ: begin
              if (row_ok) begin
                rok_nxt = 1'b1;
                re      = 1'b1;
                raddr   = cell_addr(clamp_col(in_target_col), ROW_W'(in_target_row));
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase

          // new line, scroll by one past the bottom row
          if (do_nl) begin
            cur_col_nxt = COL_W'(1);
            if (cur_row_r == ROW_W'(ROWS)) begin
              dirty_nxt = 1'b1;
              ptr_nxt   = '0;
              shift_nxt = ADDR_W'(COLUMNS);
              last_nxt  = ADDR_W'((ROWS - 1) * COLUMNS - 1);
              state_nxt = S_WAIT;
            end else begin
              cur_row_nxt = cur_row_r + 1'b1;
            end
          end
        end
      end
      S_WAIT: begin
        state_nxt = S_COPY;
      end
      S_COPY: begin
        re          = 1'b1;
        wr_en_nxt   = 1'b1;
        wr_copy_nxt = 1'b1;
        wr_addr_nxt = ptr_r;
        ptr_nxt     = ptr_r + 1'b1;
        if (ptr_r == last_r) begin
          last_nxt  = ADDR_W'(CELLS - 1);
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        wr_en_nxt   = 1'b1;
        wr_copy_nxt = 1'b0;
        wr_addr_nxt = ptr_r;
        wr_data_nxt = SPACE_CODE;
        ptr_nxt     = ptr_r + 1'b1;
        if (ptr_r == last_r) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_FILL;
      init_r    <= 1'b1;
      cur_col_r <= COL_W'(1);
      cur_row_r <= ROW_W'(1);
      dirty_r   <= 1'b1;
      ptr_r     <= '0;
      last_r    <= ADDR_W'(CELLS - 1);
      wr_en_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      init_r    <= init_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      dirty_r   <= dirty_nxt;
      ptr_r     <= ptr_nxt;
      last_r    <= last_nxt;
      wr_en_r   <= wr_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r   <= shift_nxt;
    rok_r     <= rok_nxt;
    wr_addr_r <= wr_addr_nxt;
    wr_copy_r <= wr_copy_nxt;
    wr_data_r <= wr_data_nxt;
  end

  assign in_stall      = !idle;
  assign mem_req.we    = wr_en_r;
  assign mem_req.waddr = wr_addr_r;
  assign mem_req.wdata = wr_copy_r ? rd_data : wr_data_r;
  assign mem_req.re    = re;
  assign mem_req.raddr = raddr;

  assign res_valid          = (state_r == S_DONE);
  assign result.read_data   = rok_r ? rd_data : 8'h00;
  assign result.read_ok     = rok_r;
  assign result.cursor_col  = 6'(cur_col_r);
  assign result.cursor_row  = 5'(cur_row_r);
  assign result.frame_dirty = dirty_r;

endmodule

`default_nettype wire

// File: sv/text_frame_cursor_writer.sv
// ----------------------------------------------------------------------------
// text_frame_cursor_writer
// Character-cell text frame with a 1-based cursor, screen and line clear,
// scroll and cell read, with one result beat per command beat.
//
//   channel | dir | ports
//   --------+-----+------------------------------------------------------------
//   in_     | in  | valid/stall, req_type, char_code, target_col/row,
//           |     | line_count, wrap_enable
//   out_    | out | valid/stall, read_data, read_ok, cursor_col/row, frame_dirty
//
// One command at a time; in_stall is high from acceptance until the result
// leaves the sequencer. Cursor moves, set, read, plain characters and a zero
// scroll go straight to the result. Clear sweeps the whole store, clear line
// one row, and a nonzero scroll makes one pass over the store through its
// single write port; a character that scrolls first passes a wait state.
// After reset a clearing pass over every cell runs with in_stall high. The
// output register holds a beat while out_stall is high, and the sequencer
// waits with its result until the register can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module text_frame_cursor_writer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] in_req_type,
  input  wire logic [7:0] in_char_code,
  input  wire logic [6:0] in_target_col,
  input  wire logic [6:0] in_target_row,
  input  wire logic [4:0] in_line_count,
  input  wire logic       in_wrap_enable,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data,
  output logic            out_read_ok,
  output logic [5:0]      out_cursor_col,
  output logic [4:0]      out_cursor_row,
  output logic            out_frame_dirty
);
  import tfcw_pkg::*;

  mem_req_t   mem_req;
  result_t    result;
  result_t    out_r;
  logic [7:0] rd_data;
  logic       res_valid;
  logic       res_take;
  logic       out_valid_r, out_valid_nxt;

  tfcw_cell_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  tfcw_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_target_col  (in_target_col),
    .in_target_row  (in_target_row),
    .in_line_count  (in_line_count),
    .in_wrap_enable (in_wrap_enable),
    .rd_data        (rd_data),
    .mem_req        (mem_req),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .result         (result)
  );

  assign res_take      = res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the beat while stalled
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_r.read_data;
  assign out_read_ok     = out_r.read_ok;
  assign out_cursor_col  = out_r.cursor_col;
  assign out_cursor_row  = out_r.cursor_row;
  assign out_frame_dirty = out_r.frame_dirty;

endmodule

`default_nettype wire

// File: sv/tfcw_checker.sv
// ----------------------------------------------------------------------------
// tfcw_checker
// Port-level checks on the text frame cursor writer.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_read_data,
  input wire logic       out_read_ok,
  input wire logic [5:0] out_cursor_col,
  input wire logic [4:0] out_cursor_row,
  input wire logic       out_frame_dirty
);
  import tfcw_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) &&
      $stable(out_read_ok) && $stable(out_cursor_col) && $stable(out_cursor_row))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command beat accepted while previous one in flight");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_col != 6'd0) && (out_cursor_col <= 6'(COLUMNS)) &&
      (out_cursor_row != 5'd0) && (out_cursor_row <= 5'(ROWS)))
    else $error("cursor outside the frame");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_ok |-> out_read_data == 8'h00)
    else $error("read data nonzero without read_ok");

  a_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_dirty)
    else $error("dirty mark dropped");

endmodule

bind text_frame_cursor_writer tfcw_checker u_tfcw_checker (.*);

`default_nettype wire
